>>> src/ptbl_pkg.sv
`timescale 1ns / 1ps

package ptbl_pkg;

    // leader/trailer frame pattern and its marker bit
    localparam logic [7:0] LeaderFrame = 8'o200;
    localparam int         LeaderBit   = 7;

    localparam int AddrWidth   = 12;
    localparam int WordWidth   = 12;
    localparam int NibIdxWidth = 13;

    typedef enum logic
    {
        KIND_WRITE = 1'b0,
        KIND_END   = 1'b1
    } event_kind_t;

    typedef struct packed
    {
        event_kind_t            event_kind;
        logic [AddrWidth-1:0]   word_address;
        logic [WordWidth-1:0]   word_value;
        logic [7:0]             low_byte;
        logic [NibIdxWidth-1:0] nibble_byte_index;
        logic                   nibble_upper_half;
        logic [3:0]             high_nibble;
        logic [WordWidth-1:0]   checksum_word;
        logic [AddrWidth-1:0]   end_address;
    } ptbl_result_t;

endpackage

>>> src/paper_tape_bin_loader.sv
`timescale 1ns / 1ps

// channel   dir  tdata                         tuser       tlast
// s_axis    in   tape_byte[7:0]                -           tape_end
// m_axis    out  write/end fields, 80 bits     event_kind  -
//
// one frame is taken per cycle while s_tready is high, and is parsed in one
// pass; its result, if any, lands in the output register on the same edge
// s_tready stays high while the output register is empty or being drained,
// so a stalled output blocks input only when a result is still waiting
// reset returns the parser to seeking the first leader frame, output empty

module paper_tape_bin_loader import ptbl_pkg::*;
#(
    parameter int MEM_WORDS = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // tape_byte[7:0]
    input  logic        s_tlast,   // tape_end
    output logic        m_tvalid,
    input  logic        m_tready,
    // word_address[11:0], word_value[23:12], low_byte[31:24],
    // nibble_byte_index[44:32], nibble_upper_half[45], high_nibble[49:46],
    // checksum_word[61:50], end_address[73:62], zero fill[79:74]
    output logic [79:0] m_tdata,
    output logic        m_tuser    // event_kind
);

    logic         step;
    logic         res_valid;
    ptbl_result_t res;
    ptbl_result_t out_reg;
    logic         out_valid_reg;

    assign s_tready = !out_valid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    ptbl_core #(.MEM_WORDS(MEM_WORDS)) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .tape_byte (s_tdata),
        .tape_end  (s_tlast),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            out_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_kind;
    assign m_tdata  = {6'b000000,
                       out_reg.end_address,
                       out_reg.checksum_word,
                       out_reg.high_nibble,
                       out_reg.nibble_upper_half,
                       out_reg.nibble_byte_index,
                       out_reg.low_byte,
                       out_reg.word_value,
                       out_reg.word_address};

endmodule

>>> src/ptbl_core.sv
`timescale 1ns / 1ps

module ptbl_core import ptbl_pkg::*;
#(
    parameter int MEM_WORDS = 4096
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   tape_byte,
    input  logic         tape_end,
    output logic         res_valid,
    output ptbl_result_t res
);

    typedef enum logic [1:0]
    {
        PH_SEEK,
        PH_HIGH,
        PH_LOW,
        PH_DONE
    } phase_t;

    localparam logic [NibIdxWidth-1:0] NibBase = NibIdxWidth'(MEM_WORDS);

    phase_t               phase_reg, phase_next;
    logic [6:0]           high_frame_reg, high_frame_next;
    logic [12:0]          held_word_reg, held_word_next;
    logic                 held_valid_reg, held_valid_next;
    logic [AddrWidth-1:0] load_address_reg, load_address_next;

    always_comb
    begin
        phase_next        = phase_reg;
        high_frame_next   = high_frame_reg;
        held_word_next    = held_word_reg;
        held_valid_next   = held_valid_reg;
        load_address_next = load_address_reg;
        res_valid         = 1'b0;
        res               = '0;

        if (step && phase_reg != PH_DONE)
        begin
            // an end event: tape end, or a frame with the leader bit set right after a whole word
            if (tape_end || (phase_reg == PH_HIGH && tape_byte[LeaderBit] && held_valid_reg))
            begin
                res_valid         = 1'b1;
                res.event_kind    = KIND_END;
                res.checksum_word = held_valid_reg ? held_word_reg[WordWidth-1:0] : '0;
                res.end_address   = load_address_reg;
                phase_next        = PH_DONE;
                held_valid_next   = 1'b0;
            end
            else
            begin
                case (phase_reg)
                    PH_SEEK:
                    begin
                        if (tape_byte == LeaderFrame)
                        begin
                            phase_next = PH_HIGH;
                        end
                    end
                    PH_HIGH:
                    begin
                        if (!tape_byte[LeaderBit])
                        begin
                            if (held_valid_reg)
                            begin
                                held_valid_next = 1'b0;
                                if (held_word_reg[12])
                                begin
                                    // origin word
                                    load_address_next = held_word_reg[AddrWidth-1:0];
                                end
                                else
                                begin
                                    res_valid             = 1'b1;
                                    res.event_kind        = KIND_WRITE;
                                    res.word_address      = load_address_reg;
                                    res.word_value        = held_word_reg[WordWidth-1:0];
                                    res.low_byte          = held_word_reg[7:0];
                                    res.nibble_byte_index = NibBase
                                        + {2'b00, load_address_reg[AddrWidth-1:1]};
                                    res.nibble_upper_half = load_address_reg[0];
                                    res.high_nibble       = held_word_reg[11:8];
                                    load_address_next     = load_address_reg
                                        + AddrWidth'(1);
                                end
                            end
                            high_frame_next = tape_byte[6:0];
                            phase_next      = PH_LOW;
                        end
                    end
                    PH_LOW:
                    begin
                        held_word_next  = {high_frame_reg, tape_byte[5:0]};
                        held_valid_next = 1'b1;
                        phase_next      = PH_HIGH;
                    end
                    default:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SEEK;
            high_frame_reg   <= '0;
            held_word_reg    <= '0;
            held_valid_reg   <= 1'b0;
            load_address_reg <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            high_frame_reg   <= high_frame_next;
            held_word_reg    <= held_word_next;
            held_valid_reg   <= held_valid_next;
            load_address_reg <= load_address_next;
        end
    end

endmodule

>>> sim/tb_paper_tape_bin_loader.sv
`timescale 1ns / 1ps

module tb_paper_tape_bin_loader;

    import ptbl_pkg::*;

    localparam int MEM_WORDS  = 4096;
    localparam int TAPE_LEN   = 1100;
    localparam int PHASE_LEN  = 140;
    localparam int PAUSE_AT   = 500;
    localparam int HOLD_AT    = 700;
    localparam int HOLD_LEN   = 400;
    localparam int IDLE_LIMIT = 3000;
    localparam int TAIL_WAIT  = 10;

    typedef enum logic [1:0]
    {
        PH_SEEK,
        PH_HIGH,
        PH_LOW,
        PH_DONE
    } tape_phase_t;

    typedef enum
    {
        CLOSE_TRAILER,
        CLOSE_FLAG_HELD,
        CLOSE_FLAG_MIDWORD
    } tape_close_t;

    typedef struct packed
    {
        logic [7:0] frame;
        logic       last;
    } tape_frame_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        m_tuser;

    paper_tape_bin_loader #(.MEM_WORDS(MEM_WORDS)) dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    tape_frame_t  tape_frames [$];
    ptbl_result_t due_events  [$];

    // loader state as predicted
    tape_phase_t  tape_phase = PH_SEEK;
    logic [6:0]   hi_frame   = '0;
    logic [12:0]  held_item  = '0;
    logic         held_ok    = 1'b0;
    logic [11:0]  load_addr  = '0;

    int send_idle_pct [4] = '{0, 58, 0, 21};
    int recv_stall_pct[4] = '{0, 0, 58, 21};

    int          offered     = 0;
    int          frames_in   = 0;
    int          writes_seen = 0;
    int          ends_seen   = 0;
    int          origin_cnt  = 0;
    int          fail_cnt    = 0;
    int          idle_run    = 0;
    int          hold_left   = 0;
    logic        hold_done   = 1'b0;
    logic        pause_done  = 1'b0;
    logic        in_taken    = 1'b0;
    tape_close_t close_mode;

    task automatic add_frame(input logic [7:0] frame, input logic last);
        tape_frame_t f;
        f.frame = frame;
        f.last  = last;
        tape_frames.push_back(f);
    endtask

    // high frame carries origin flag and bits 11..6, low frame bits 5..0 plus junk on top
    task automatic add_word(input logic origin, input logic [11:0] value);
        add_frame({1'b0, origin, value[11:6]}, 1'b0);
        add_frame({2'($urandom), value[5:0]}, 1'b0);
    endtask

    task automatic close_tape();
        ptbl_result_t r;
        r               = '0;
        r.event_kind    = KIND_END;
        r.checksum_word = held_ok ? held_item[11:0] : 12'd0;
        r.end_address   = load_addr;
        due_events.push_back(r);
        tape_phase = PH_DONE;
        held_ok    = 1'b0;
    endtask

    task automatic parse_frame(input logic [7:0] frame, input logic last);
        ptbl_result_t r;
        r = '0;
        if (tape_phase == PH_DONE)
            return;
        if (last)
        begin
            close_tape();
            return;
        end
        case (tape_phase)
            PH_SEEK:
            begin
                if (frame == LeaderFrame)
                    tape_phase = PH_HIGH;
            end
            PH_HIGH:
            begin
                if (frame[LeaderBit])
                begin
                    if (held_ok)
                        close_tape();
                end
                else
                begin
                    if (held_ok)
                    begin
                        held_ok = 1'b0;
                        if (held_item[12])
                        begin
                            load_addr = held_item[11:0];
                            origin_cnt++;
                        end
                        else
                        begin
                            r.event_kind        = KIND_WRITE;
                            r.word_address      = load_addr;
                            r.word_value        = held_item[11:0];
                            r.low_byte          = held_item[7:0];
                            r.nibble_byte_index = 13'(MEM_WORDS + (load_addr >> 1));
                            r.nibble_upper_half = load_addr[0];
                            r.high_nibble       = held_item[11:8];
                            due_events.push_back(r);
                            load_addr = load_addr + 12'd1;
                        end
                    end
                    hi_frame   = frame[6:0];
                    tape_phase = PH_LOW;
                end
            end
            PH_LOW:
            begin
                held_item  = {hi_frame, frame[5:0]};
                held_ok    = 1'b1;
                tape_phase = PH_HIGH;
            end
            default:
                tape_phase = PH_DONE;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_cnt++;
        end
    endtask

    // sample both sides, predict, compare, watch for a hang
    always @(posedge clk)
    begin : monitor
        ptbl_result_t want;
        if (rst_n)
        begin
            in_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                if (due_events.size() == 0)
                begin
                    $error("result with no expected event: kind %0d data 0x%0h",
                           m_tuser, m_tdata);
                    fail_cnt++;
                end
                else
                begin
                    want = due_events.pop_front();
                    check_field("event_kind", want.event_kind, m_tuser);
                    check_field("word_address", want.word_address, m_tdata[11:0]);
                    check_field("word_value", want.word_value, m_tdata[23:12]);
                    check_field("low_byte", want.low_byte, m_tdata[31:24]);
                    check_field("nibble_byte_index", want.nibble_byte_index,
                                m_tdata[44:32]);
                    check_field("nibble_upper_half", want.nibble_upper_half, m_tdata[45]);
                    check_field("high_nibble", want.high_nibble, m_tdata[49:46]);
                    check_field("checksum_word", want.checksum_word, m_tdata[61:50]);
                    check_field("end_address", want.end_address, m_tdata[73:62]);
                    if (want.event_kind == KIND_END)
                        ends_seen++;
                    else
                        writes_seen++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                parse_frame(s_tdata, s_tlast);
                frames_in++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_run = 0;
            else
                idle_run++;
            if (idle_run >= IDLE_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // sender: one frame at a time from the tape queue
    always @(negedge clk)
    begin : driver
        tape_frame_t f;
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (offered == PAUSE_AT && !pause_done)
            begin
                // hold the tape until every pending event has drained
                s_tvalid <= 1'b0;
                if (due_events.size() == 0)
                    pause_done <= 1'b1;
            end
            else if (tape_frames.size() > 0 &&
                     $urandom_range(99) >= send_idle_pct[(offered / PHASE_LEN) % 4])
            begin
                f = tape_frames.pop_front();
                s_tdata  <= f.frame;
                s_tlast  <= f.last;
                s_tvalid <= 1'b1;
                offered  <= offered + 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: random stalls, one long hold-off to back up the input
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                m_tready  <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (!hold_done && frames_in >= HOLD_AT)
            begin
                m_tready  <= 1'b0;
                hold_left <= HOLD_LEN;
                hold_done <= 1'b1;
            end
            else
                m_tready <= $urandom_range(99) >= recv_stall_pct[(offered / PHASE_LEN) % 4];
        end
    end

    initial
    begin
        logic        origin;
        logic [11:0] value;

        // noise before the first leader, then extra leaders that are skipped
        add_frame(8'h00, 1'b0);
        add_frame(8'hFF, 1'b0);
        add_frame(8'o201, 1'b0);
        add_frame(8'h7F, 1'b0);
        add_frame(LeaderFrame, 1'b0);
        add_frame(8'o377, 1'b0);
        add_frame(8'o300, 1'b0);
        add_frame(LeaderFrame, 1'b0);
        // origin near the top so the address wraps, then edge values
        add_word(1'b1, 12'o7776);
        add_word(1'b0, 12'o7777);
        add_word(1'b0, 12'o0000);
        add_word(1'b0, 12'hA5A);
        add_word(1'b1, 12'o0000);
        add_word(1'b1, 12'o4001);
        add_word(1'b0, 12'h0FF);
        add_word(1'b0, 12'hF00);

        while (tape_frames.size() < TAPE_LEN)
        begin
            origin = ($urandom_range(7) == 0);
            if (origin)
                value = $urandom_range(1) ? 12'($urandom_range(4095, 4088)) : 12'($urandom);
            else
                case ($urandom_range(9))
                    0:       value = 12'h000;
                    1:       value = 12'hFFF;
                    default: value = 12'($urandom);
                endcase
            add_word(origin, value);
        end

        close_mode = tape_close_t'($urandom_range(2));
        case (close_mode)
            CLOSE_TRAILER:   add_frame(LeaderFrame, 1'b0);
            CLOSE_FLAG_HELD: add_frame(8'($urandom), 1'b1);
            default:
            begin
                // end flag right after a high frame: nothing held
                add_frame({1'b0, 7'($urandom)}, 1'b0);
                add_frame(8'($urandom), 1'b1);
            end
        endcase
        // anything after the end event must be dropped
        add_frame(LeaderFrame, 1'b0);
        add_frame(8'($urandom), 1'b1);
        repeat (4)
            add_frame(8'($urandom), 1'($urandom));

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        while (tape_frames.size() > 0 || s_tvalid)
            @(negedge clk);
        while (due_events.size() > 0)
            @(negedge clk);
        repeat (TAIL_WAIT) @(negedge clk);

        $display("%0d frames fed, %0d memory writes, %0d origin words, %0d end events",
                 frames_in, writes_seen, origin_cnt, ends_seen);
        $display("tape closed by %s, final load address 0x%0h", close_mode.name(), load_addr);
        if (fail_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> paper_tape_bin_loader.f
src/ptbl_pkg.sv
src/ptbl_core.sv
src/paper_tape_bin_loader.sv
sim/tb_paper_tape_bin_loader.sv
